/* src/ipe_pkg.sv */
package ipe_pkg;

    localparam int MAX_PRIMS = 64;

    localparam int CFG_W = 7;
    localparam logic [CFG_W-1:0] BUDGET_RESET = 7'd64;

    localparam int BUD_W = $clog2(MAX_PRIMS + 1);
    localparam int QW    = $clog2(MAX_PRIMS + 1);
    localparam int KW    = $clog2(QW);
    localparam int TW    = 2 * QW;
    localparam int SAT_Q = MAX_PRIMS + 1;

    localparam int APB_AW = 3;
    localparam logic REG_PRIM_BUDGET = 1'b0;

    localparam int S_TDATA_W = 144;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 104;
    localparam int M_TUSER_W = 3;

    localparam logic [1:0] KIND_FLAT   = 2'd0;
    localparam logic [1:0] KIND_QUAD   = 2'd1;
    localparam logic [1:0] KIND_SPRITE = 2'd2;
    localparam logic [1:0] KIND_TPAGE  = 2'd3;

    localparam logic [2:0] MODE_SIMPLE = 3'd0;
    localparam logic [2:0] MODE_SLICED = 3'd1;
    localparam logic [2:0] MODE_TILED  = 3'd2;
    localparam logic [2:0] MODE_FILL_H = 3'd3;
    localparam logic [2:0] MODE_FILL_V = 3'd4;

    localparam logic [1:0] ROUTE_FLAT   = 2'd0;
    localparam logic [1:0] ROUTE_SPRITE = 2'd1;
    localparam logic [1:0] ROUTE_SLICE  = 2'd2;
    localparam logic [1:0] ROUTE_TILE   = 2'd3;

    localparam logic [12:0] FILL_ONE   = 13'd4096;
    localparam int          FILL_SHIFT = 12;
    localparam logic [7:0]  SLICE_DEF  = 8'd255;
    localparam logic [7:0]  TILE_DEF   = 8'd16;

    typedef struct packed {
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic signed [15:0] rect_w;
        logic signed [15:0] rect_h;
        logic               is_flat;
        logic [2:0]         image_mode;
        logic [12:0]        fill_amount;
        logic [7:0]         tex_u;
        logic [7:0]         tex_v;
        logic [7:0]         tex_w;
        logic [7:0]         tex_h;
        logic [31:0]        slice_borders;
    } item_t;

    typedef struct packed {
        logic [1:0]  prim_kind;
        logic [16:0] pos_x;
        logic [16:0] pos_y;
        logic [16:0] prim_w;
        logic [16:0] prim_h;
        logic [7:0]  out_u;
        logic [7:0]  out_v;
        logic [9:0]  span_u;
        logic [9:0]  span_v;
        logic        last;
        logic        truncated;
    } prim_t;

    typedef struct packed {
        logic load;
        logic fill;
        logic prep;
        logic div_step;
        logic count;
        logic step;
    } cmd_t;

    typedef struct packed {
        logic       skip;
        logic [1:0] route;
        logic       div_last;
        logic       out_free;
        logic       fin;
    } stat_t;

endpackage

/* src/ipe_ctrl.sv */
module ipe_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  ipe_pkg::stat_t stat,
    output ipe_pkg::cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FILL  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_COUNT = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_ready    = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_FILL;
                end
            end
            S_FILL: begin
                cmd.fill   = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                cmd.prep = 1'b1;
                if (stat.skip) begin
                    state_next = S_IDLE;
                end else if (stat.route == ipe_pkg::ROUTE_TILE) begin
                    state_next = S_DIV;
                end else if (stat.route == ipe_pkg::ROUTE_SLICE) begin
                    state_next = S_COUNT;
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = S_COUNT;
                end
            end
            S_COUNT: begin
                cmd.count  = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.step = 1'b1;
                    if (stat.fin) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* src/ipe_datapath.sv */
module ipe_datapath (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  ipe_pkg::item_t             s_item,
    input  logic [ipe_pkg::CFG_W-1:0]  budget_cfg,
    input  ipe_pkg::cmd_t              cmd,
    output ipe_pkg::stat_t             stat,
    input  logic                       m_ready,
    output logic                       m_valid,
    output ipe_pkg::prim_t             m_prim
);

    typedef struct packed {
        logic [2:0][17:0] pos;
        logic [2:0][17:0] len;
        logic [2:0][7:0]  tex;
        logic [2:0][9:0]  span;
    } axis_t;

    function automatic axis_t slice_axis(input logic signed [15:0] org,
                                         input logic signed [15:0] size,
                                         input logic [7:0] torg,
                                         input logic [7:0] tsize,
                                         input logic [7:0] b0,
                                         input logic [7:0] b1);
        axis_t a;
        logic signed [17:0] o;
        logic signed [17:0] s;
        logic signed [17:0] e0;
        logic signed [17:0] e1;
        o         = 18'(org);
        s         = 18'(size);
        e0        = {10'b0, b0};
        e1        = {10'b0, b1};
        a.pos[0]  = o;
        a.pos[1]  = o + e0;
        a.pos[2]  = o + s - e1;
        a.len[0]  = e0;
        a.len[1]  = s - e0 - e1;
        a.len[2]  = e1;
        a.tex[0]  = torg;
        a.tex[1]  = torg + b0;
        a.tex[2]  = torg + tsize - b1;
        a.span[0] = {2'b0, b0} - 10'd1;
        a.span[1] = {2'b0, tsize} - {2'b0, b0} - {2'b0, b1} - 10'd1;
        a.span[2] = {2'b0, b1} - 10'd1;
        return a;
    endfunction

    ipe_pkg::item_t     it_reg;
    logic signed [15:0] w_reg;
    logic signed [15:0] h_reg;

    logic [12:0]        amt_sat;
    logic signed [15:0] fill_op;
    logic signed [29:0] fill_prod;
    logic signed [15:0] fill_res;

    logic [ipe_pkg::BUD_W-1:0] bud;
    logic [1:0]                route_c;
    logic [7:0]                sw_slice;
    logic [7:0]                sh_slice;
    logic [7:0]                sw_tile;
    logic [7:0]                sh_tile;

    axis_t col_reg;
    axis_t row_reg;
    logic [2:0] colv;
    logic [2:0] rowv;
    logic [1:0] cx_reg;
    logic [1:0] cy_reg;

    logic [7:0]             dvx_reg;
    logic [7:0]             dvy_reg;
    logic [15:0]            remx_reg;
    logic [15:0]            remy_reg;
    logic [ipe_pkg::QW-1:0] qx_reg;
    logic [ipe_pkg::QW-1:0] qy_reg;
    logic                   satx_reg;
    logic                   saty_reg;
    logic [ipe_pkg::KW-1:0] k_reg;
    logic [15:0]            remx_init;
    logic [15:0]            remy_init;
    logic [16:0]            shx;
    logic [16:0]            shy;

    logic [ipe_pkg::QW-1:0] nxs;
    logic [ipe_pkg::QW-1:0] nys;
    logic [ipe_pkg::TW-1:0] tiles;
    logic                   tpage_c;
    logic [1:0]             ncols;
    logic [1:0]             nrows;
    logic [3:0]             ncells;
    logic                   slice_over;

    logic [1:0]                route_reg;
    logic [ipe_pkg::BUD_W-1:0] n_reg;
    logic [ipe_pkg::BUD_W-1:0] emit_cnt_reg;
    logic                      trunc_reg;
    logic                      tpage_reg;
    logic                      phase_reg;
    logic [15:0]               tx_reg;
    logic [15:0]               ty_reg;

    logic [16:0]        w_u;
    logic [16:0]        h_u;
    logic [16:0]        tx_end;
    logic [16:0]        ty_end;
    logic [15:0]        tile_w;
    logic [15:0]        tile_h;
    logic signed [17:0] tile_px;
    logic signed [17:0] tile_py;
    logic               at_count;

    ipe_pkg::prim_t cand;
    logic           cand_v;
    logic           fin_c;

    ipe_pkg::prim_t out_reg;
    logic           m_valid_reg;

    always_comb begin
        if (it_reg.fill_amount > ipe_pkg::FILL_ONE) begin
            amt_sat = ipe_pkg::FILL_ONE;
        end else begin
            amt_sat = it_reg.fill_amount;
        end
        fill_op   = (it_reg.image_mode == ipe_pkg::MODE_FILL_V) ? it_reg.rect_h : it_reg.rect_w;
        fill_prod = fill_op * $signed({1'b0, amt_sat});
        fill_res  = fill_prod[ipe_pkg::FILL_SHIFT+15:ipe_pkg::FILL_SHIFT];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            it_reg <= s_item;
        end
        if (cmd.fill) begin
            w_reg <= (it_reg.image_mode == ipe_pkg::MODE_FILL_H) ? fill_res : it_reg.rect_w;
            h_reg <= (it_reg.image_mode == ipe_pkg::MODE_FILL_V) ? fill_res : it_reg.rect_h;
        end
    end

    always_comb begin
        if (budget_cfg == '0) begin
            bud = ipe_pkg::BUD_W'(1);
        end else if (budget_cfg > ipe_pkg::CFG_W'(ipe_pkg::MAX_PRIMS)) begin
            bud = ipe_pkg::BUD_W'(ipe_pkg::MAX_PRIMS);
        end else begin
            bud = ipe_pkg::BUD_W'(budget_cfg);
        end

        if (it_reg.is_flat) begin
            route_c = ipe_pkg::ROUTE_FLAT;
        end else if (it_reg.image_mode == ipe_pkg::MODE_SLICED) begin
            route_c = ipe_pkg::ROUTE_SLICE;
        end else if (it_reg.image_mode == ipe_pkg::MODE_TILED) begin
            route_c = ipe_pkg::ROUTE_TILE;
        end else begin
            route_c = ipe_pkg::ROUTE_SPRITE;
        end

        sw_slice  = (it_reg.tex_w == 8'd0) ? ipe_pkg::SLICE_DEF : it_reg.tex_w;
        sh_slice  = (it_reg.tex_h == 8'd0) ? ipe_pkg::SLICE_DEF : it_reg.tex_h;
        sw_tile   = (it_reg.tex_w == 8'd0) ? ipe_pkg::TILE_DEF : it_reg.tex_w;
        sh_tile   = (it_reg.tex_h == 8'd0) ? ipe_pkg::TILE_DEF : it_reg.tex_h;
        remx_init = 16'(w_reg) + 16'(sw_tile) - 16'd1;
        remy_init = 16'(h_reg) + 16'(sh_tile) - 16'd1;
    end

    // Tile counts saturate one above the largest budget, which is all the
    // truncation decision needs.
    assign shx = 17'(dvx_reg) << k_reg;
    assign shy = 17'(dvy_reg) << k_reg;

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            dvx_reg  <= sw_tile;
            dvy_reg  <= sh_tile;
            remx_reg <= remx_init;
            remy_reg <= remy_init;
            satx_reg <= 17'(remx_init) >= 17'(sw_tile) * 17'(ipe_pkg::SAT_Q);
            saty_reg <= 17'(remy_init) >= 17'(sh_tile) * 17'(ipe_pkg::SAT_Q);
            qx_reg   <= '0;
            qy_reg   <= '0;
            k_reg    <= ipe_pkg::KW'(ipe_pkg::QW - 1);
        end else if (cmd.div_step) begin
            if (17'(remx_reg) >= shx) begin
                remx_reg <= remx_reg - shx[15:0];
                qx_reg   <= {qx_reg[ipe_pkg::QW-2:0], 1'b1};
            end else begin
                qx_reg   <= {qx_reg[ipe_pkg::QW-2:0], 1'b0};
            end
            if (17'(remy_reg) >= shy) begin
                remy_reg <= remy_reg - shy[15:0];
                qy_reg   <= {qy_reg[ipe_pkg::QW-2:0], 1'b1};
            end else begin
                qy_reg   <= {qy_reg[ipe_pkg::QW-2:0], 1'b0};
            end
            k_reg <= k_reg - 1'b1;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            colv[i] = !col_reg.len[i][17] && (col_reg.len[i] != '0);
            rowv[i] = !row_reg.len[i][17] && (row_reg.len[i] != '0);
        end
        ncols      = 2'($countones(colv));
        nrows      = 2'($countones(rowv));
        ncells     = 4'(ncols) * 4'(nrows);
        slice_over = 8'(ncells) > 8'(bud);
        nxs        = satx_reg ? ipe_pkg::QW'(ipe_pkg::SAT_Q) : qx_reg;
        nys        = saty_reg ? ipe_pkg::QW'(ipe_pkg::SAT_Q) : qy_reg;
        tiles      = ipe_pkg::TW'(nxs) * ipe_pkg::TW'(nys);
        tpage_c    = ipe_pkg::TW'(bud) > tiles;
    end

    always_comb begin
        w_u      = {1'b0, w_reg};
        h_u      = {1'b0, h_reg};
        tx_end   = 17'(tx_reg) + 17'(dvx_reg);
        ty_end   = 17'(ty_reg) + 17'(dvy_reg);
        tile_w   = (tx_end > w_u) ? (w_reg - tx_reg) : 16'(dvx_reg);
        tile_h   = (ty_end > h_u) ? (h_reg - ty_reg) : 16'(dvy_reg);
        tile_px  = 18'(it_reg.rect_x) + $signed({2'b0, tx_reg});
        tile_py  = 18'(it_reg.rect_y) + $signed({2'b0, ty_reg});
        at_count = (ipe_pkg::BUD_W'(n_reg + 1'b1) == emit_cnt_reg);
    end

    always_comb begin
        cand   = '0;
        cand_v = 1'b0;
        fin_c  = 1'b0;
        case (route_reg)
            ipe_pkg::ROUTE_FLAT: begin
                cand.prim_kind = ipe_pkg::KIND_FLAT;
                cand.pos_x     = 17'(it_reg.rect_x);
                cand.pos_y     = 17'(it_reg.rect_y);
                cand.prim_w    = 17'(w_reg);
                cand.prim_h    = 17'(h_reg);
                cand.last      = 1'b1;
                cand_v         = 1'b1;
                fin_c          = 1'b1;
            end
            ipe_pkg::ROUTE_SPRITE: begin
                cand_v = 1'b1;
                if (!phase_reg) begin
                    cand.prim_kind = ipe_pkg::KIND_SPRITE;
                    cand.pos_x     = 17'(it_reg.rect_x);
                    cand.pos_y     = 17'(it_reg.rect_y);
                    cand.prim_w    = 17'(w_reg);
                    cand.prim_h    = 17'(h_reg);
                    cand.out_u     = it_reg.tex_u;
                    cand.out_v     = it_reg.tex_v;
                end else begin
                    cand.prim_kind = ipe_pkg::KIND_TPAGE;
                    cand.last      = 1'b1;
                    fin_c          = 1'b1;
                end
            end
            ipe_pkg::ROUTE_SLICE: begin
                cand.prim_kind = ipe_pkg::KIND_QUAD;
                cand.pos_x     = col_reg.pos[cx_reg][16:0];
                cand.pos_y     = row_reg.pos[cy_reg][16:0];
                cand.prim_w    = col_reg.len[cx_reg][16:0];
                cand.prim_h    = row_reg.len[cy_reg][16:0];
                cand.out_u     = col_reg.tex[cx_reg];
                cand.out_v     = row_reg.tex[cy_reg];
                cand.span_u    = col_reg.span[cx_reg];
                cand.span_v    = row_reg.span[cy_reg];
                cand_v         = colv[cx_reg] && rowv[cy_reg] && (n_reg < bud);
                cand.last      = cand_v && at_count;
                fin_c          = ((cx_reg == 2'd2) && (cy_reg == 2'd2)) || cand.last;
            end
            ipe_pkg::ROUTE_TILE: begin
                cand_v = 1'b1;
                if (!phase_reg) begin
                    cand.prim_kind = ipe_pkg::KIND_SPRITE;
                    cand.pos_x     = tile_px[16:0];
                    cand.pos_y     = tile_py[16:0];
                    cand.prim_w    = 17'(tile_w);
                    cand.prim_h    = 17'(tile_h);
                    cand.out_u     = it_reg.tex_u;
                    cand.out_v     = it_reg.tex_v;
                    cand.last      = !tpage_reg && at_count;
                    fin_c          = cand.last;
                end else begin
                    cand.prim_kind = ipe_pkg::KIND_TPAGE;
                    cand.last      = 1'b1;
                    fin_c          = 1'b1;
                end
            end
            default: begin
                fin_c = 1'b1;
            end
        endcase
        cand.truncated = trunc_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            route_reg <= route_c;
            col_reg   <= slice_axis(it_reg.rect_x, w_reg, it_reg.tex_u, sw_slice,
                                    it_reg.slice_borders[7:0], it_reg.slice_borders[23:16]);
            row_reg   <= slice_axis(it_reg.rect_y, h_reg, it_reg.tex_v, sh_slice,
                                    it_reg.slice_borders[15:8], it_reg.slice_borders[31:24]);
            cx_reg    <= 2'd0;
            cy_reg    <= 2'd0;
            tx_reg    <= '0;
            ty_reg    <= '0;
            n_reg     <= '0;
            phase_reg <= 1'b0;
            trunc_reg <= 1'b0;
            tpage_reg <= 1'b0;
        end else if (cmd.count) begin
            if (route_reg == ipe_pkg::ROUTE_TILE) begin
                tpage_reg    <= tpage_c;
                trunc_reg    <= !tpage_c;
                emit_cnt_reg <= tpage_c ? tiles[ipe_pkg::BUD_W-1:0] : bud;
            end else begin
                trunc_reg    <= slice_over;
                emit_cnt_reg <= slice_over ? bud : ipe_pkg::BUD_W'(ncells);
            end
        end else if (cmd.step) begin
            if (cand_v) begin
                n_reg <= n_reg + 1'b1;
            end
            if (route_reg == ipe_pkg::ROUTE_SLICE) begin
                if (cx_reg == 2'd2) begin
                    cx_reg <= 2'd0;
                    cy_reg <= cy_reg + 1'b1;
                end else begin
                    cx_reg <= cx_reg + 1'b1;
                end
            end else if (route_reg == ipe_pkg::ROUTE_TILE) begin
                if (tx_end >= w_u) begin
                    tx_reg <= '0;
                    ty_reg <= ty_end[15:0];
                end else begin
                    tx_reg <= tx_end[15:0];
                end
                if (at_count && tpage_reg) begin
                    phase_reg <= 1'b1;
                end
            end else begin
                phase_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.step && cand_v) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step && cand_v) begin
            out_reg <= cand;
        end
    end

    always_comb begin
        stat.skip     = (w_reg <= 16'sd0) || (h_reg <= 16'sd0)
                        || ((route_c == ipe_pkg::ROUTE_SPRITE) && (bud < ipe_pkg::BUD_W'(2)));
        stat.route    = route_c;
        stat.div_last = (k_reg == '0);
        stat.out_free = !m_valid_reg || m_ready;
        stat.fin      = fin_c;
    end

    assign m_valid = m_valid_reg;
    assign m_prim  = out_reg;

endmodule

/* src/image_primitive_emitter_top.sv */
// Channel   Direction  Fields
// s_        in         tdata: rect_x/y/w/h, fill_amount, tex_u/v/w/h, slice_borders
//                      tuser: is_flat, image_mode
// m_        out        tdata: pos_x/y, prim_w/h, out_u/v, span_u/v
//                      tuser: prim_kind, truncated   tlast: last
// apb       in         prim_budget at byte address 0
//
// A widget is taken in the idle state, then the fill multiply and the setup follow in turn.
// Flat and sprite widgets then emit directly, sliced widgets count their cells and step through
// the cell grid, and tiled widgets run the tile count divider before counting and emitting.
// Reset is synchronous, active low, and returns prim_budget to 64.
// A stalled result holds the controller in its emit state; the next widget is taken
// once the last primitive sits in the output register.
module image_primitive_emitter_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // rect_x, rect_y, rect_w, rect_h, fill_amount, tex_u, tex_v, tex_w, tex_h, slice_borders
    input  logic [ipe_pkg::S_TDATA_W-1:0]     s_tdata,
    // is_flat, image_mode
    input  logic [ipe_pkg::S_TUSER_W-1:0]     s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // pos_x, pos_y, prim_w, prim_h, out_u, out_v, span_u, span_v
    output logic [ipe_pkg::M_TDATA_W-1:0]     m_tdata,
    // prim_kind, truncated
    output logic [ipe_pkg::M_TUSER_W-1:0]     m_tuser,
    output logic                              m_tlast,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ipe_pkg::APB_AW-1:0]        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    logic [ipe_pkg::CFG_W-1:0] budget_reg;
    logic                      reg_idx;
    ipe_pkg::item_t            item;
    ipe_pkg::prim_t            prim;
    ipe_pkg::cmd_t             cmd;
    ipe_pkg::stat_t            stat;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ipe_pkg::APB_AW-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            budget_reg <= ipe_pkg::BUDGET_RESET;
        end else if (psel && penable && pwrite && pready
                     && (reg_idx == ipe_pkg::REG_PRIM_BUDGET)) begin
            budget_reg <= pwdata[ipe_pkg::CFG_W-1:0];
        end
    end

    always_comb begin
        if (reg_idx == ipe_pkg::REG_PRIM_BUDGET) begin
            prdata = 32'(budget_reg);
        end else begin
            prdata = '0;
        end
    end

    always_comb begin
        item.rect_x        = s_tdata[15:0];
        item.rect_y        = s_tdata[31:16];
        item.rect_w        = s_tdata[47:32];
        item.rect_h        = s_tdata[63:48];
        item.fill_amount   = s_tdata[76:64];
        item.tex_u         = s_tdata[84:77];
        item.tex_v         = s_tdata[92:85];
        item.tex_w         = s_tdata[100:93];
        item.tex_h         = s_tdata[108:101];
        item.slice_borders = s_tdata[140:109];
        item.is_flat       = s_tuser[0];
        item.image_mode    = s_tuser[3:1];
    end

    ipe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ipe_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_item     (item),
        .budget_cfg (budget_reg),
        .cmd        (cmd),
        .stat       (stat),
        .m_ready    (m_tready),
        .m_valid    (m_tvalid),
        .m_prim     (prim)
    );

    assign m_tdata = {prim.span_v, prim.span_u, prim.out_v, prim.out_u,
                      prim.prim_h, prim.prim_w, prim.pos_y, prim.pos_x};
    assign m_tuser = {prim.truncated, prim.prim_kind};
    assign m_tlast = prim.last;

endmodule

/* src/ipe_checker.sv */
module ipe_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ipe_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [ipe_pkg::M_TUSER_W-1:0] m_tuser,
    input logic                          m_tlast
);

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again while a widget is in work");

    a_tpage_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[1:0] == ipe_pkg::KIND_TPAGE) |-> m_tlast)
        else $error("texture page select is not the final item");

    a_flat_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[1:0] == ipe_pkg::KIND_FLAT) |-> m_tlast && !m_tuser[2])
        else $error("flat tile is not a lone untruncated item");

endmodule

bind image_primitive_emitter_top ipe_checker u_ipe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

/* sim/primitive_checker.sv */
module primitive_checker
    import ipe_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [M_TUSER_W-1:0] m_tuser,
    input  logic                 m_tlast,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic                 pready,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [31:0]          pwdata,
    output int                   mismatches,
    output int                   pending,
    output int                   prims_checked
);

    int    budget_reg;
    int    fails;
    int    seen;
    prim_t expected_prims[$];

    function automatic prim_t make_prim(input logic [1:0] kind, input int x, input int y,
                                        input int pw, input int ph, input int u, input int v,
                                        input int su, input int sv);
        prim_t p;
        p.prim_kind = kind;
        p.pos_x     = x[16:0];
        p.pos_y     = y[16:0];
        p.prim_w    = pw[16:0];
        p.prim_h    = ph[16:0];
        p.out_u     = u[7:0];
        p.out_v     = v[7:0];
        p.span_u    = su[9:0];
        p.span_v    = sv[9:0];
        p.last      = 1'b0;
        p.truncated = 1'b0;
        return p;
    endfunction

    function automatic void predict_widget(input item_t w);
        prim_t       batch[$];
        int          bud, amt, rx, ry, rw, rh, fw, fh, tu, tv, sw, sh;
        int          xs[4], ys[4], us[4], vs[4];
        int          pw, ph, tx, ty, n;
        int unsigned nx, ny, tiles;
        bit          cut;
        bud = budget_reg;
        if (bud < 1) begin
            bud = 1;
        end
        if (bud > MAX_PRIMS) begin
            bud = MAX_PRIMS;
        end
        amt = int'(w.fill_amount);
        if (amt > int'(FILL_ONE)) begin
            amt = int'(FILL_ONE);
        end
        rx = int'(w.rect_x);
        ry = int'(w.rect_y);
        rw = int'(w.rect_w);
        rh = int'(w.rect_h);
        tu = int'(w.tex_u);
        tv = int'(w.tex_v);
        cut = 1'b0;
        if (rw <= 0 || rh <= 0) begin
            return;
        end
        fw = rw;
        fh = rh;
        if (w.image_mode == MODE_FILL_H) begin
            fw = (rw * amt) >>> FILL_SHIFT;
        end else if (w.image_mode == MODE_FILL_V) begin
            fh = (rh * amt) >>> FILL_SHIFT;
        end
        if (fw <= 0 || fh <= 0) begin
            return;
        end

        if (w.is_flat) begin
            batch.push_back(make_prim(KIND_FLAT, rx, ry, fw, fh, 0, 0, 0, 0));
        end else if (w.image_mode == MODE_SLICED) begin
            sw = (w.tex_w != 0) ? int'(w.tex_w) : int'(SLICE_DEF);
            sh = (w.tex_h != 0) ? int'(w.tex_h) : int'(SLICE_DEF);
            xs[0] = rx;
            xs[1] = rx + int'(w.slice_borders[7:0]);
            xs[2] = rx + fw - int'(w.slice_borders[23:16]);
            xs[3] = rx + fw;
            ys[0] = ry;
            ys[1] = ry + int'(w.slice_borders[15:8]);
            ys[2] = ry + fh - int'(w.slice_borders[31:24]);
            ys[3] = ry + fh;
            us[0] = tu;
            us[1] = tu + int'(w.slice_borders[7:0]);
            us[2] = tu + sw - int'(w.slice_borders[23:16]);
            us[3] = tu + sw;
            vs[0] = tv;
            vs[1] = tv + int'(w.slice_borders[15:8]);
            vs[2] = tv + sh - int'(w.slice_borders[31:24]);
            vs[3] = tv + sh;
            for (int cy = 0; cy < 3; cy++) begin
                for (int cx = 0; cx < 3; cx++) begin
                    pw = xs[cx+1] - xs[cx];
                    ph = ys[cy+1] - ys[cy];
                    if (pw > 0 && ph > 0) begin
                        if (batch.size() >= bud) begin
                            cut = 1'b1;
                        end else begin
                            batch.push_back(make_prim(KIND_QUAD, xs[cx], ys[cy], pw, ph,
                                                      us[cx], vs[cy],
                                                      us[cx+1] - us[cx] - 1,
                                                      vs[cy+1] - vs[cy] - 1));
                        end
                    end
                end
            end
        end else if (w.image_mode == MODE_TILED) begin
            sw = (w.tex_w != 0) ? int'(w.tex_w) : int'(TILE_DEF);
            sh = (w.tex_h != 0) ? int'(w.tex_h) : int'(TILE_DEF);
            nx = (fw + sw - 1) / sw;
            ny = (fh + sh - 1) / sh;
            tiles = nx * ny;
            tx = 0;
            ty = 0;
            n = 0;
            while (n < bud && n < tiles) begin
                pw = (tx + sw > fw) ? fw - tx : sw;
                ph = (ty + sh > fh) ? fh - ty : sh;
                batch.push_back(make_prim(KIND_SPRITE, rx + tx, ry + ty, pw, ph, tu, tv, 0, 0));
                n++;
                tx += sw;
                if (tx >= fw) begin
                    tx = 0;
                    ty += sh;
                end
            end
            if (bud > tiles) begin
                batch.push_back(make_prim(KIND_TPAGE, 0, 0, 0, 0, 0, 0, 0, 0));
            end else begin
                cut = 1'b1;
            end
        end else begin
            if (bud < 2) begin
                return;
            end
            batch.push_back(make_prim(KIND_SPRITE, rx, ry, fw, fh, tu, tv, 0, 0));
            batch.push_back(make_prim(KIND_TPAGE, 0, 0, 0, 0, 0, 0, 0, 0));
        end

        foreach (batch[i]) begin
            batch[i].truncated = cut;
            batch[i].last      = (i == batch.size() - 1);
            expected_prims.push_back(batch[i]);
        end
    endfunction

    function automatic void show_prim(input string tag, input prim_t p);
        $display("  %s kind=%0d x=%0d y=%0d w=%0d h=%0d u=%0d v=%0d su=%0d sv=%0d last=%0b trunc=%0b",
                 tag, p.prim_kind, $signed(p.pos_x), $signed(p.pos_y), $signed(p.prim_w),
                 $signed(p.prim_h), p.out_u, p.out_v, $signed(p.span_u), $signed(p.span_v),
                 p.last, p.truncated);
    endfunction

    always @(posedge aclk) begin
        prim_t got;
        prim_t want;
        item_t w;
        if (!aresetn) begin
            budget_reg = int'(BUDGET_RESET);
            expected_prims.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == {REG_PRIM_BUDGET, 2'b00}) begin
                budget_reg = int'(pwdata[CFG_W-1:0]);
            end
            if (m_tvalid && m_tready) begin
                got.prim_kind = m_tuser[1:0];
                got.truncated = m_tuser[2];
                got.last      = m_tlast;
                got.pos_x     = m_tdata[16:0];
                got.pos_y     = m_tdata[33:17];
                got.prim_w    = m_tdata[50:34];
                got.prim_h    = m_tdata[67:51];
                got.out_u     = m_tdata[75:68];
                got.out_v     = m_tdata[83:76];
                got.span_u    = m_tdata[93:84];
                got.span_v    = m_tdata[103:94];
                seen++;
                if (expected_prims.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("Mismatch %0d: primitive with no widget behind it", fails);
                        show_prim("got", got);
                    end
                end else begin
                    want = expected_prims.pop_front();
                    if (got.prim_kind !== want.prim_kind || got.pos_x !== want.pos_x ||
                        got.pos_y !== want.pos_y || got.prim_w !== want.prim_w ||
                        got.prim_h !== want.prim_h || got.out_u !== want.out_u ||
                        got.out_v !== want.out_v || got.span_u !== want.span_u ||
                        got.span_v !== want.span_v || got.last !== want.last ||
                        got.truncated !== want.truncated) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("Mismatch %0d: primitive %0d differs", fails, seen);
                            show_prim("exp", want);
                            show_prim("got", got);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                w.rect_x        = s_tdata[15:0];
                w.rect_y        = s_tdata[31:16];
                w.rect_w        = s_tdata[47:32];
                w.rect_h        = s_tdata[63:48];
                w.fill_amount   = s_tdata[76:64];
                w.tex_u         = s_tdata[84:77];
                w.tex_v         = s_tdata[92:85];
                w.tex_w         = s_tdata[100:93];
                w.tex_h         = s_tdata[108:101];
                w.slice_borders = s_tdata[140:109];
                w.is_flat       = s_tuser[0];
                w.image_mode    = s_tuser[3:1];
                predict_widget(w);
            end
        end
        mismatches    <= fails;
        pending       <= expected_prims.size();
        prims_checked <= seen;
    end

endmodule

/* sim/testbench.sv */
module testbench;
    import ipe_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_HOLD  = 100;
    localparam int SEG_ITEMS   = 49;

    localparam logic [2:0] MODE_UNUSED_A = 3'd5;
    localparam logic [2:0] MODE_UNUSED_B = 3'd6;
    localparam logic [2:0] MODE_UNUSED_C = 3'd7;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [APB_AW-1:0]    paddr    = '0;
    logic [31:0]          pwdata   = '0;
    logic [31:0]          prdata;
    logic                 pready;

    int send_idle     = 0;
    int recv_stall    = 0;
    int widgets_sent  = 0;
    int budget_writes = 0;
    int quiet         = 0;
    int mismatches;
    int pending;
    int prims_checked;

    always #10 aclk = ~aclk;

    image_primitive_emitter_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    primitive_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .mismatches    (mismatches),
        .pending       (pending),
        .prims_checked (prims_checked)
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic item_t widget(input int x, input int y, input int w, input int h,
                                     input bit flat, input logic [2:0] mode, input int fill,
                                     input int u, input int v, input int tw, input int th,
                                     input logic [31:0] borders);
        item_t it;
        it.rect_x        = x[15:0];
        it.rect_y        = y[15:0];
        it.rect_w        = w[15:0];
        it.rect_h        = h[15:0];
        it.is_flat       = flat;
        it.image_mode    = mode;
        it.fill_amount   = fill[12:0];
        it.tex_u         = u[7:0];
        it.tex_v         = v[7:0];
        it.tex_w         = tw[7:0];
        it.tex_h         = th[7:0];
        it.slice_borders = borders;
        return it;
    endfunction

    function automatic int rand_coord();
        if ($urandom_range(0, 99) < 10) begin
            return $urandom_range(0, 65535);
        end
        return int'($urandom_range(0, 600)) - 300;
    endfunction

    function automatic int rand_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6) begin
            return -int'($urandom_range(0, 32768));
        end else if (r < 12) begin
            return $urandom_range(0, 65535);
        end
        return $urandom_range(1, 160);
    endfunction

    function automatic int rand_texel_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            return 0;
        end else if (r < 40) begin
            return $urandom_range(0, 255);
        end
        return $urandom_range(1, 40);
    endfunction

    function automatic item_t random_widget();
        logic [2:0]  mode;
        int          fill;
        logic [31:0] borders;
        if ($urandom_range(0, 99) < 10) begin
            mode = 3'($urandom_range(MODE_UNUSED_A, MODE_UNUSED_C));
        end else begin
            mode = 3'($urandom_range(MODE_SIMPLE, MODE_FILL_V));
        end
        if ($urandom_range(0, 99) < 15) begin
            fill = $urandom_range(FILL_ONE + 1, 8191);
        end else begin
            fill = $urandom_range(0, FILL_ONE);
        end
        if ($urandom_range(0, 99) < 30) begin
            borders = $urandom;
        end else begin
            borders = {8'($urandom_range(0, 24)), 8'($urandom_range(0, 24)),
                       8'($urandom_range(0, 24)), 8'($urandom_range(0, 24))};
        end
        return widget(rand_coord(), rand_coord(), rand_size(), rand_size(),
                      ($urandom_range(0, 99) < 12), mode, fill,
                      $urandom_range(0, 255), $urandom_range(0, 255),
                      rand_texel_size(), rand_texel_size(), borders);
    endfunction

    task automatic send_widget(input item_t w);
        bit taken;
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({w.slice_borders, w.tex_h, w.tex_w, w.tex_v, w.tex_u,
                                w.fill_amount, w.rect_h, w.rect_w, w.rect_y, w.rect_x});
        s_tuser  <= {w.image_mode, w.is_flat};
        taken = 1'b0;
        while (!taken) begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end
        widgets_sent++;
    endtask

    task automatic drain_widgets();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_HOLD) @(posedge aclk);
    endtask

    task automatic write_budget(input logic [CFG_W-1:0] val);
        logic [31:0] noise;
        noise = $urandom;
        drain_widgets();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_PRIM_BUDGET, 2'b00};
        pwdata  <= {noise[31:CFG_W], val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        budget_writes++;
    endtask

    initial begin
        logic [CFG_W-1:0] budget_plan [0:7];
        budget_plan = '{7'd1, 7'd0, 7'd2, 7'd127, 7'd9, 7'd3, 7'd64, 7'd0};
        budget_plan[7] = CFG_W'($urandom_range(0, 127));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_widget(widget(10, 20, 40, 30, 0, MODE_SIMPLE, 0, 5, 6, 32, 32, 0));
        send_widget(widget(-32768, 32767, 32767, 32767, 0, MODE_SIMPLE, 8191,
                           255, 255, 255, 255, 32'hFFFF_FFFF));
        send_widget(widget(0, 0, 5, 7, 1, MODE_SIMPLE, 0, 9, 9, 9, 9, 0));
        send_widget(widget(100, 50, 60, 40, 1, MODE_SLICED, 0, 1, 1, 8, 8, 32'h0404_0404));
        send_widget(widget(16, 16, 80, 64, 0, MODE_SLICED, 0, 3, 4, 0, 0, 32'h040A_0608));
        send_widget(widget(0, 0, 30, 30, 0, MODE_SLICED, 0, 0, 0, 64, 64, 0));
        send_widget(widget(-5, -5, 20, 12, 0, MODE_SLICED, 0, 200, 250, 8, 8, 32'h0A1E_0F19));
        send_widget(widget(0, 0, 600, 600, 0, MODE_SLICED, 0, 255, 255, 255, 255,
                           32'hFFFF_FFFF));
        send_widget(widget(0, 0, 48, 32, 0, MODE_TILED, 0, 10, 20, 0, 0, 0));
        send_widget(widget(7, 9, 50, 21, 0, MODE_TILED, 0, 1, 2, 16, 8, 0));
        send_widget(widget(0, 0, 128, 128, 0, MODE_TILED, 0, 0, 0, 16, 16, 0));
        send_widget(widget(0, 0, 144, 112, 0, MODE_TILED, 0, 0, 0, 16, 16, 0));
        send_widget(widget(0, 0, 32767, 32767, 0, MODE_TILED, 0, 0, 0, 1, 1, 0));
        send_widget(widget(0, 0, 100, 40, 0, MODE_FILL_H, 2048, 7, 7, 16, 16, 0));
        send_widget(widget(0, 0, 100, 40, 0, MODE_FILL_V, 8191, 7, 7, 16, 16, 0));
        send_widget(widget(0, 0, 100, 40, 0, MODE_FILL_H, 0, 7, 7, 16, 16, 0));
        send_widget(widget(0, 0, 30, 3, 0, MODE_FILL_V, 1000, 7, 7, 16, 16, 0));
        send_widget(widget(5, 5, 64, 64, 1, MODE_FILL_H, 1024, 0, 0, 0, 0, 0));
        send_widget(widget(5, 5, 0, 64, 0, MODE_SIMPLE, 0, 0, 0, 0, 0, 0));
        send_widget(widget(5, 5, 64, -32768, 0, MODE_SIMPLE, 0, 0, 0, 0, 0, 0));
        send_widget(widget(1, 2, 3, 4, 0, MODE_UNUSED_A, 0, 11, 12, 0, 0, 0));
        send_widget(widget(1, 2, 3, 4, 0, MODE_UNUSED_B, 100, 11, 12, 0, 0, 0));
        send_widget(widget(1, 2, 3, 4, 1, MODE_UNUSED_C, 0, 11, 12, 0, 0, 0));

        for (int seg = 0; seg < 8; seg++) begin
            write_budget(budget_plan[seg]);
            case (seg % 4)
                0: begin
                    send_idle  = 0;
                    recv_stall = 0;
                end
                1: begin
                    send_idle  = 48;
                    recv_stall = 0;
                end
                2: begin
                    send_idle  = 0;
                    recv_stall = 48;
                end
                default: begin
                    send_idle  = 21;
                    recv_stall = 21;
                end
            endcase
            for (int k = 0; k < SEG_ITEMS; k++) begin
                send_widget(random_widget());
            end
        end

        drain_widgets();
        $display("Ran %0d widgets through %0d budget settings and four pacing mixes;",
                 widgets_sent, budget_writes + 1);
        $display("%0d primitives were compared against the prediction.", prims_checked);
        if (mismatches == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
